// ===== rtl/sos_pkg.sv =====
`timescale 1ns / 1ps

package sos_pkg;

  // default geometry and data width
  localparam int unsigned MAX_ROWS_DEF   = 8;
  localparam int unsigned MAX_COLS_DEF   = 8;
  localparam int unsigned DATA_WIDTH_DEF = 16;

  // configuration port
  localparam int unsigned SIZE_W    = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SIZE_W-1:0] ROW_COUNT_RST    = 4'd8;
  localparam logic [SIZE_W-1:0] COLUMN_COUNT_RST = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT    = 2'd0,
    CFG_COLUMN_COUNT = 2'd1
  } cfg_idx_e;

  // status of the spiral walker toward the top level
  typedef struct packed {
    logic active;
    logic last;
  } walk_stat_t;

endpackage

// ===== rtl/sos_walk.sv =====
`timescale 1ns / 1ps

module sos_walk import sos_pkg::*; #(
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = MAX_COLS_DEF,
  localparam int unsigned DEPTH   = MAX_ROWS * MAX_COLS,
  localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned NW      = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              launch_i,
  input  logic [SIZE_W-1:0] rows_i,
  input  logic [SIZE_W-1:0] cols_i,
  input  logic [NW-1:0]     total_i,
  output logic [AW-1:0]     addr_o,
  output walk_stat_t        stat_o
);

  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_DOWN,
    DIR_LEFT,
    DIR_UP
  } dir_e;

  dir_e            dir_q;
  logic            active_q;
  logic [RW-1:0]   row_q, top_q, bottom_q;
  logic [CW-1:0]   col_q, left_q, right_q;
  logic [NW-1:0]   cnt_q, total_q, cols_q;
  logic            last;

  assign last = (cnt_q == (total_q - NW'(1)));

  // linear store address of the current cell
  assign addr_o = AW'(NW'(row_q) * cols_q + NW'(col_q));

  assign stat_o.active = active_q;
  assign stat_o.last   = last;

  // walk the bounds clockwise, turning when a segment is used up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      dir_q    <= DIR_RIGHT;
      cnt_q    <= '0;
      total_q  <= '0;
      cols_q   <= '0;
      row_q    <= '0;
      col_q    <= '0;
      top_q    <= '0;
      left_q   <= '0;
      bottom_q <= '0;
      right_q  <= '0;
    end else if (launch_i) begin
      active_q <= 1'b1;
      dir_q    <= DIR_RIGHT;
      cnt_q    <= '0;
      total_q  <= total_i;
      cols_q   <= NW'(cols_i);
      row_q    <= '0;
      col_q    <= '0;
      top_q    <= '0;
      left_q   <= '0;
      bottom_q <= RW'(rows_i - SIZE_W'(1));
      right_q  <= CW'(cols_i - SIZE_W'(1));
    end else if (active_q) begin
      cnt_q <= cnt_q + NW'(1);
      if (last) begin
        active_q <= 1'b0;
      end
      case (dir_q)
        DIR_RIGHT: begin
          if (col_q != right_q) begin
            col_q <= col_q + CW'(1);
          end else begin
            dir_q <= DIR_DOWN;
            top_q <= top_q + RW'(1);
            row_q <= row_q + RW'(1);
          end
        end
        DIR_DOWN: begin
          if (row_q != bottom_q) begin
            row_q <= row_q + RW'(1);
          end else begin
            dir_q   <= DIR_LEFT;
            right_q <= right_q - CW'(1);
            col_q   <= col_q - CW'(1);
          end
        end
        DIR_LEFT: begin
          if (col_q != left_q) begin
            col_q <= col_q - CW'(1);
          end else begin
            dir_q    <= DIR_UP;
            bottom_q <= bottom_q - RW'(1);
            row_q    <= row_q - RW'(1);
          end
        end
        DIR_UP: begin
          if (row_q != top_q) begin
            row_q <= row_q - RW'(1);
          end else begin
            dir_q  <= DIR_RIGHT;
            left_q <= left_q + CW'(1);
            col_q  <= col_q + CW'(1);
          end
        end
        default: begin
          dir_q <= DIR_RIGHT;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // a new matrix never launches over a walk in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(launch_i && active_q))
    else $error("walk launched while active");

  // the emit count stays inside the matrix
  assert property (@(posedge clk_i) disable iff (!rst_ni) active_q |-> (cnt_q < total_q))
    else $error("walk count ran past matrix size");

  // the walk stops right after its final cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && last && !launch_i) |=> !active_q)
    else $error("walk kept running after last cell");
`endif

endmodule

// ===== rtl/spiral_order_scan_top.sv =====
`timescale 1ns / 1ps
// channel  | ports                                      | handshake
// ---------+--------------------------------------------+------------------------------
// input    | start_i, busy_o, element_value_i           | taken when start_i && !busy_o
// config   | cfg_valid_i, cfg_ready_o, cfg_index_i,     | written when valid && ready
//          | cfg_data_i                                 |
// result   | out_valid_o, out_value_o, out_last_o       | one-cycle strobe, no back-pressure
//
// the item that completes the matrix starts a walk that holds busy_o high until every
// element of the matrix has been read from the store, one element read per cycle
// each result follows its walk step in the next cycle, from the registered store read port
// reset clears the load count and restores both sizes to 8; the store is not cleared
// the receiver cannot stall, so results are never held back

module spiral_order_scan_top import sos_pkg::*; #(
  parameter int unsigned MAX_ROWS   = MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS   = MAX_COLS_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [DATA_WIDTH-1:0] element_value_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [SIZE_W-1:0]            cfg_data_i,
  output logic                         out_valid_o,
  output logic signed [DATA_WIDTH-1:0] out_value_o,
  output logic                         out_last_o
);

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW    = $clog2(DEPTH + 1);

  logic [SIZE_W-1:0]     row_count_q, column_count_q;
  logic [SIZE_W-1:0]     rows_eff, cols_eff;
  logic [NW-1:0]         total, load_count_q, load_next;
  logic                  accept, complete;
  logic [AW-1:0]         rd_addr;
  walk_stat_t            walk_stat;
  logic [DATA_WIDTH-1:0] store_q [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic                  out_valid_q, out_last_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= ROW_COUNT_RST;
      column_count_q <= COLUMN_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ROW_COUNT:    row_count_q    <= cfg_data_i;
        CFG_COLUMN_COUNT: column_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp sizes into 1..max
  always_comb begin
    if (row_count_q == '0) begin
      rows_eff = SIZE_W'(1);
    end else if (row_count_q > SIZE_W'(MAX_ROWS)) begin
      rows_eff = SIZE_W'(MAX_ROWS);
    end else begin
      rows_eff = row_count_q;
    end
    if (column_count_q == '0) begin
      cols_eff = SIZE_W'(1);
    end else if (column_count_q > SIZE_W'(MAX_COLS)) begin
      cols_eff = SIZE_W'(MAX_COLS);
    end else begin
      cols_eff = column_count_q;
    end
  end

  assign total     = NW'(rows_eff) * NW'(cols_eff);
  assign load_next = load_count_q + NW'(1);
  assign accept    = start_i && !busy_o;
  assign complete  = accept && (load_next >= total);
  assign busy_o    = walk_stat.active;

  // load counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_count_q <= '0;
    end else if (accept) begin
      load_count_q <= complete ? '0 : load_next;
    end
  end

  // element store, one write port for loading and one registered read port
  always_ff @(posedge clk_i) begin
    if (accept) begin
      store_q[load_count_q[AW-1:0]] <= element_value_i;
    end
    if (walk_stat.active) begin
      rd_data_q <= store_q[rd_addr];
    end
  end

  sos_walk #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .launch_i (complete),
    .rows_i   (rows_eff),
    .cols_i   (cols_eff),
    .total_i  (total),
    .addr_o   (rd_addr),
    .stat_o   (walk_stat)
  );

  // result strobe lines up with the read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      out_valid_q <= walk_stat.active;
      out_last_q  <= walk_stat.active && walk_stat.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign out_value_o = rd_data_q;

endmodule
